// ----- rtl/ppt_pkg.sv -----
// Package for the C preprocessing token lexer: token kinds, lexer modes,
// result word layout and the byte classification functions.
// Depends on nothing; used by the lexer and its checker.
`default_nettype none

package ppt_pkg;

  localparam logic [5:0] K_UNKNOWN    = 6'd0;
  localparam logic [5:0] K_NEWLINE    = 6'd1;
  localparam logic [5:0] K_SPACE      = 6'd2;
  localparam logic [5:0] K_NUMBER     = 6'd3;
  localparam logic [5:0] K_ELLIPSIS   = 6'd4;
  localparam logic [5:0] K_STRING     = 6'd5;
  localparam logic [5:0] K_CHAR       = 6'd6;
  localparam logic [5:0] K_IDENT      = 6'd7;
  localparam logic [5:0] K_PUNCT      = 6'd8;
  localparam logic [5:0] K_EQ_EQ      = 6'd9;
  localparam logic [5:0] K_NOT_EQ     = 6'd10;
  localparam logic [5:0] K_LESS_EQ    = 6'd11;
  localparam logic [5:0] K_GREATER_EQ = 6'd12;
  localparam logic [5:0] K_AND_AND    = 6'd13;
  localparam logic [5:0] K_OR_OR      = 6'd14;
  localparam logic [5:0] K_STAR       = 6'd15;
  localparam logic [5:0] K_SLASH      = 6'd16;
  localparam logic [5:0] K_AMP        = 6'd17;
  localparam logic [5:0] K_PERCENT    = 6'd18;
  localparam logic [5:0] K_PLUS       = 6'd19;
  localparam logic [5:0] K_MINUS      = 6'd20;
  localparam logic [5:0] K_LESS       = 6'd21;
  localparam logic [5:0] K_GREATER    = 6'd22;
  localparam logic [5:0] K_CARET      = 6'd23;
  localparam logic [5:0] K_BAR        = 6'd24;
  localparam logic [5:0] K_QUESTION   = 6'd25;
  localparam logic [5:0] K_COLON      = 6'd26;
  localparam logic [5:0] K_BANG       = 6'd27;
  localparam logic [5:0] K_HASH       = 6'd28;
  localparam logic [5:0] K_SEMI       = 6'd29;
  localparam logic [5:0] K_COMMA      = 6'd30;
  localparam logic [5:0] K_LBRACE     = 6'd31;
  localparam logic [5:0] K_RBRACE     = 6'd32;
  localparam logic [5:0] K_LPAREN     = 6'd33;
  localparam logic [5:0] K_RPAREN     = 6'd34;
  localparam logic [5:0] K_HASH_HASH  = 6'd35;

  localparam logic [7:0] CH_NL = 8'h0A;
  localparam logic [7:0] CH_DQ = 8'h22;
  localparam logic [7:0] CH_SQ = 8'h27;

  typedef enum logic [6:0] {
    M_IDLE    = 7'b0000001,
    M_SPACE   = 7'b0000010,
    M_NUM     = 7'b0000100,
    M_NUM_E   = 7'b0001000,
    M_QUOTE   = 7'b0010000,
    M_IDENT   = 7'b0100000,
    M_COMMENT = 7'b1000000
  } mode_e;

  typedef struct packed {
    logic        last;
    logic        cmt;
    logic        unterm;
    logic [15:0] len;
    logic [31:0] start;
    logic [5:0]  kind;
  } res_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] kind;
  } pair_t;

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_letter(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
  endfunction

  function automatic logic id_start(logic [7:0] c);
    return is_letter(c) || c[7];
  endfunction

  function automatic logic id_cont(logic [7:0] c);
    return id_start(c) || is_digit(c);
  endfunction

  function automatic logic is_xdigit(logic [7:0] c);
    return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0B || c == 8'h0C;
  endfunction

  function automatic logic is_sign(logic [7:0] c);
    return c == "+" || c == "-";
  endfunction

  function automatic logic is_punct_byte(logic [7:0] c);
    return c >= 8'h21 && c <= 8'h7E && !is_letter(c) && !is_digit(c);
  endfunction

  function automatic logic starts_pair(logic [7:0] c);
    return c == "=" || c == "!" || c == "<" || c == ">" || c == "-" || c == "+" ||
           c == "*" || c == "/" || c == "%" || c == "&" || c == "|" || c == "^" ||
           c == "#";
  endfunction

  function automatic pair_t pair_kind(logic [7:0] a, logic [7:0] b);
    pair_t p;
    p.ok   = 1'b1;
    p.kind = K_PUNCT;
    case ({a, b})
      {"=", "="}: p.kind = K_EQ_EQ;
      {"!", "="}: p.kind = K_NOT_EQ;
      {"<", "="}: p.kind = K_LESS_EQ;
      {">", "="}: p.kind = K_GREATER_EQ;
      {"&", "&"}: p.kind = K_AND_AND;
      {"|", "|"}: p.kind = K_OR_OR;
      {"#", "#"}: p.kind = K_HASH_HASH;
      {"-", ">"}, {"+", "="}, {"-", "="}, {"*", "="}, {"/", "="}, {"+", "+"},
      {"-", "-"}, {"%", "="}, {"&", "="}, {"|", "="}, {"^", "="}, {"<", "<"},
      {">", ">"}: p.kind = K_PUNCT;
      default: p.ok = 1'b0;
    endcase
    return p;
  endfunction

  function automatic logic [5:0] single_kind(logic [7:0] c);
    logic [5:0] k;
    case (c)
      "*": k = K_STAR;
      "/": k = K_SLASH;
      "&": k = K_AMP;
      "%": k = K_PERCENT;
      "+": k = K_PLUS;
      "-": k = K_MINUS;
      "<": k = K_LESS;
      ">": k = K_GREATER;
      "^": k = K_CARET;
      "|": k = K_BAR;
      "?": k = K_QUESTION;
      ":": k = K_COLON;
      "!": k = K_BANG;
      "#": k = K_HASH;
      ";": k = K_SEMI;
      ",": k = K_COMMA;
      "{": k = K_LBRACE;
      "}": k = K_RBRACE;
      "(": k = K_LPAREN;
      ")": k = K_RPAREN;
      default: k = K_PUNCT;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/c_preprocessor_tokenizer.sv -----
// Top level of the C preprocessing token lexer: lexer state, lookahead and
// a four-word result queue. Depends on ppt_pkg.
//
// Channel  Dir  tdata (lowest bit up)                         tlast
// s_axis   in   source_byte[7:0]                              end_of_text
// m_axis   out  kind[5:0] start[37:6] length[53:38]           last_token
//               unterminated[54] line_comment[55]
//
// One byte is taken per cycle while the input is ready; its tokens (up to three) enter the result
// queue at the same edge and leave it one word per cycle while the output is ready.
// The input is ready while the queue holds at most one word, so a stalled
// output holds the input back once two or more words wait in the queue.
// Reset clears the lexer to offset zero and empties the queue.
`default_nettype none

module c_preprocessor_tokenizer import ppt_pkg::*; #(
  parameter longint unsigned MAX_TOKEN_LENGTH = 65535,
  parameter int unsigned     POSITION_BITS    = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // source_byte
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [55:0]      m_axis_tdata,   // kind, start, length, unterminated, comment
  output logic             m_axis_tlast
);

  localparam int unsigned LB = $clog2(MAX_TOKEN_LENGTH + 1);
  localparam int unsigned PB = POSITION_BITS;
  localparam logic [LB-1:0] MaxLen = LB'(MAX_TOKEN_LENGTH);

  function automatic logic [LB-1:0] sat_add(logic [LB-1:0] l, logic [1:0] k);
    logic [LB:0] s;
    s = {1'b0, l} + (LB + 1)'(k);
    if (s > {1'b0, MaxLen}) return MaxLen;
    return s[LB-1:0];
  endfunction

  mode_e         mode_q, mode_d;
  logic [7:0]    la_q [3];
  logic [7:0]    la_d [3];
  logic [1:0]    cnt_q, cnt_d;
  logic [PB-1:0] head_q, head_d;
  logic [PB-1:0] tb_q, tb_d;
  logic [LB-1:0] len_q, len_d;
  logic          dq_q, dq_d;

  logic [PB-1:0] hpos [4];
  logic          in_fire, eot, done, s1, s2, em;
  logic [7:0]    c, b, d;
  logic [1:0]    off, kd, nres;
  logic [PB-1:0] hp;
  logic [5:0]    em_kind;
  logic [PB-1:0] em_st;
  logic [LB-1:0] em_len;
  logic          em_un, em_cm;
  pair_t         pk;
  res_t          res [3];

  res_t          fifo_q [4];
  logic [1:0]    wr_q, rd_q;
  logic [2:0]    fcnt_q;
  logic          pop;

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign eot     = s_axis_tlast;

  for (genvar i = 0; i < 4; i++) begin : g_hpos
    assign hpos[i] = head_q + PB'(i);
  end

  always_comb begin
    mode_d = mode_q;
    la_d   = la_q;
    cnt_d  = cnt_q;
    tb_d   = tb_q;
    len_d  = len_q;
    dq_d   = dq_q;
    off    = 2'd0;
    nres   = 2'd0;
    done   = 1'b0;
    c = '0; b = '0; d = '0; s1 = 1'b0; s2 = 1'b0; hp = '0; kd = '0; pk = '0;
    em = 1'b0; em_kind = '0; em_st = '0; em_len = '0; em_un = 1'b0; em_cm = 1'b0;
    for (int i = 0; i < 3; i++) res[i] = '0;
    if (in_fire) begin
      if (cnt_d != 2'd3) begin
        la_d[cnt_d] = s_axis_tdata;
        cnt_d       = cnt_d + 2'd1;
      end
      for (int it = 0; it < 6; it++) begin
        if (!done) begin
          c  = la_d[0];
          b  = (cnt_d >= 2'd2) ? la_d[1] : 8'd0;
          d  = (cnt_d == 2'd3) ? la_d[2] : 8'd0;
          s1 = (cnt_d < 2'd2) && !eot;
          s2 = (cnt_d < 2'd3) && !eot;
          hp = hpos[off];
          pk = pair_kind(c, b);
          kd = 2'd0;
          em = 1'b0;
          em_un = 1'b0;
          em_cm = 1'b0;
          em_st = tb_d;
          em_len = len_d;
          em_kind = K_UNKNOWN;
          if (mode_d == M_IDLE) begin
            em_st = hp;
            if (cnt_d == 2'd0) begin
              done = 1'b1;
            end else if (c == CH_NL) begin
              em = 1'b1; em_kind = K_NEWLINE; em_len = LB'(1); kd = 2'd1;
            end else if (c == "/" && s1) begin
              done = 1'b1;
            end else if (c == "/" && cnt_d >= 2'd2 && b == "/") begin
              mode_d = M_COMMENT; tb_d = hp; len_d = LB'(2); kd = 2'd2;
            end else if (is_space(c)) begin
              mode_d = M_SPACE; tb_d = hp; len_d = LB'(1); kd = 2'd1;
            end else if (is_digit(c)) begin
              mode_d = M_NUM; tb_d = hp; len_d = LB'(1); kd = 2'd1;
            end else if (c == "." && s1) begin
              done = 1'b1;
            end else if (c == "." && cnt_d >= 2'd2 && is_digit(b)) begin
              mode_d = M_NUM; tb_d = hp; len_d = LB'(1); kd = 2'd1;
            end else if (c == "." && cnt_d >= 2'd2 && b == "." && s2) begin
              done = 1'b1;
            end else if (c == "." && cnt_d == 2'd3 && b == "." && d == ".") begin
              em = 1'b1; em_kind = K_ELLIPSIS; em_len = LB'(3); kd = 2'd3;
            end else if (c == CH_DQ || c == CH_SQ) begin
              dq_d = (c == CH_DQ);
              mode_d = M_QUOTE; tb_d = hp; len_d = LB'(1); kd = 2'd1;
            end else if (id_start(c)) begin
              mode_d = M_IDENT; tb_d = hp; len_d = LB'(1); kd = 2'd1;
            end else if (c == "*" && s1) begin
              done = 1'b1;
            end else if (c == "*" && cnt_d >= 2'd2 && id_start(b)) begin
              mode_d = M_IDENT; tb_d = hp; len_d = LB'(1); kd = 2'd1;
            end else if ((c == "<" || c == ">") && s1) begin
              done = 1'b1;
            end else if ((c == "<" || c == ">") && cnt_d >= 2'd2 && b == c && s2) begin
              done = 1'b1;
            end else if ((c == "<" || c == ">") && cnt_d == 2'd3 && b == c && d == "=") begin
              em = 1'b1; em_kind = K_PUNCT; em_len = LB'(3); kd = 2'd3;
            end else if (starts_pair(c) && s1) begin
              done = 1'b1;
            end else if (starts_pair(c) && cnt_d >= 2'd2 && pk.ok) begin
              em = 1'b1; em_kind = pk.kind; em_len = LB'(2); kd = 2'd2;
            end else begin
              em = 1'b1; em_len = LB'(1); kd = 2'd1;
              em_kind = is_punct_byte(c) ? single_kind(c) : K_UNKNOWN;
            end
          end else if (cnt_d == 2'd0) begin
            done = 1'b1;
          end else begin
            case (mode_d)
              M_SPACE: begin
                if (is_space(c)) begin
                  kd = 2'd1; len_d = sat_add(len_d, 2'd1);
                end else begin
                  em = 1'b1; em_kind = K_SPACE; mode_d = M_IDLE;
                end
              end
              M_NUM, M_NUM_E: begin
                if (mode_d == M_NUM_E && is_sign(c)) begin
                  kd = 2'd1; len_d = sat_add(len_d, 2'd1); mode_d = M_NUM;
                end else if (c == "p" || c == "P") begin
                  if (cnt_d < 2'd2 && !eot) begin
                    done = 1'b1;
                  end else if (cnt_d >= 2'd2 && is_sign(la_d[1])) begin
                    kd = 2'd2; len_d = sat_add(len_d, 2'd2); mode_d = M_NUM;
                  end else begin
                    em = 1'b1; em_kind = K_NUMBER; mode_d = M_IDLE;
                  end
                end else if (is_xdigit(c) || c == "x" || c == ".") begin
                  kd = 2'd1; len_d = sat_add(len_d, 2'd1);
                  mode_d = (c == "e" || c == "E") ? M_NUM_E : M_NUM;
                end else begin
                  if (c == "L") begin
                    kd = 2'd1; len_d = sat_add(len_d, 2'd1);
                  end
                  em = 1'b1; em_kind = K_NUMBER; em_len = len_d; mode_d = M_IDLE;
                end
              end
              M_QUOTE: begin
                if (c == (dq_d ? CH_DQ : CH_SQ)) begin
                  kd = 2'd1; len_d = sat_add(len_d, 2'd1);
                  em = 1'b1; em_len = len_d; mode_d = M_IDLE;
                  em_kind = dq_d ? K_STRING : K_CHAR;
                end else if (c == CH_NL) begin
                  em = 1'b1; em_un = 1'b1; mode_d = M_IDLE;
                  em_kind = dq_d ? K_STRING : K_CHAR;
                end else begin
                  kd = 2'd1; len_d = sat_add(len_d, 2'd1);
                end
              end
              M_IDENT: begin
                if (id_cont(c)) begin
                  kd = 2'd1; len_d = sat_add(len_d, 2'd1);
                end else begin
                  em = 1'b1; em_kind = K_IDENT; mode_d = M_IDLE;
                end
              end
              M_COMMENT: begin
                kd = 2'd1; len_d = sat_add(len_d, 2'd1);
              end
              default: mode_d = M_IDLE;
            endcase
          end
          if (em && nres != 2'd3) begin
            res[nres].kind   = em_kind;
            res[nres].start  = 32'(em_st);
            res[nres].len    = 16'(em_len);
            res[nres].unterm = em_un;
            res[nres].cmt    = em_cm;
            res[nres].last   = 1'b0;
            nres = nres + 2'd1;
          end
          case (kd)
            2'd1: begin
              la_d[0] = la_d[1]; la_d[1] = la_d[2];
            end
            2'd2: la_d[0] = la_d[2];
            default: ;
          endcase
          cnt_d = cnt_d - kd;
          off   = off + kd;
        end
      end
      if (eot) begin
        em = 1'b1; em_un = 1'b0; em_cm = 1'b0; em_kind = K_UNKNOWN;
        case (mode_d)
          M_SPACE:        em_kind = K_SPACE;
          M_NUM, M_NUM_E: em_kind = K_NUMBER;
          M_QUOTE: begin
            em_kind = dq_d ? K_STRING : K_CHAR; em_un = 1'b1;
          end
          M_IDENT:        em_kind = K_IDENT;
          M_COMMENT:      em_cm = 1'b1;
          default:        em = 1'b0;
        endcase
        if (em && nres != 2'd3) begin
          res[nres].kind   = em_kind;
          res[nres].start  = 32'(tb_d);
          res[nres].len    = 16'(len_d);
          res[nres].unterm = em_un;
          res[nres].cmt    = em_cm;
          res[nres].last   = 1'b0;
          nres = nres + 2'd1;
        end
        if (nres != 2'd0) res[nres - 2'd1].last = 1'b1;
        mode_d = M_IDLE;
        for (int i = 0; i < 3; i++) la_d[i] = 8'd0;
        cnt_d = 2'd0;
        tb_d  = '0;
        len_d = '0;
        dq_d  = 1'b0;
      end
    end
  end

  assign head_d = (in_fire && eot) ? '0 : hpos[off];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      for (int i = 0; i < 3; i++) la_q[i] <= 8'd0;
      cnt_q  <= 2'd0;
      head_q <= '0;
      tb_q   <= '0;
      len_q  <= '0;
      dq_q   <= 1'b0;
    end else begin
      mode_q <= mode_d;
      la_q   <= la_d;
      cnt_q  <= cnt_d;
      head_q <= head_d;
      tb_q   <= tb_d;
      len_q  <= len_d;
      dq_q   <= dq_d;
    end
  end

  assign pop           = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = fcnt_q < 3'd2;
  assign m_axis_tvalid = fcnt_q != 3'd0;
  assign m_axis_tdata  = {fifo_q[rd_q].cmt, fifo_q[rd_q].unterm, fifo_q[rd_q].len,
                          fifo_q[rd_q].start, fifo_q[rd_q].kind};
  assign m_axis_tlast  = fifo_q[rd_q].last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= 2'd0;
      rd_q   <= 2'd0;
      fcnt_q <= 3'd0;
    end else begin
      wr_q   <= wr_q + nres;
      rd_q   <= rd_q + 2'(pop);
      fcnt_q <= fcnt_q + 3'(nres) - 3'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < nres) fifo_q[wr_q + 2'(i)] <= res[i];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ppt_checker.sv -----
// Port-level checker for the C preprocessing token lexer, with the bind
// that attaches it to c_preprocessor_tokenizer. Depends on ppt_pkg.
`default_nettype none

module ppt_checker import ppt_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [55:0] m_axis_tdata,
  input wire logic        m_axis_tlast
);

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result word withdrawn while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result word changed while stalled");

  // A swallowed comment is always the unknown kind and closes the text.
  a_comment_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[55] |-> m_axis_tdata[5:0] == K_UNKNOWN && m_axis_tlast &&
    !m_axis_tdata[54])
    else $error("comment word malformed");

  // Only string and char literals can lack their closing quote.
  a_unterm_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[54] |-> m_axis_tdata[5:0] == K_STRING ||
    m_axis_tdata[5:0] == K_CHAR)
    else $error("unterminated flag on a non-literal");

  // With no word waiting the input side is always open.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input held back with an empty queue");

endmodule

bind c_preprocessor_tokenizer ppt_checker u_ppt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
